// File: rtl/two_source_frame_mixer_core_defines.svh
// Assertion macros for the frame mixer core.
`ifndef TWO_SOURCE_FRAME_MIXER_CORE_DEFINES_SVH
`define TWO_SOURCE_FRAME_MIXER_CORE_DEFINES_SVH

`ifndef SYNTH
`define TSFM_ASSERT(name, clk_i, rstn_i, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rstn_i) (expr)) \
    else $error("tsfm assertion failed");
`define TSFM_ASSERT_IMP(name, clk_i, rstn_i, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error("tsfm implication failed");
`else
`define TSFM_ASSERT(name, clk_i, rstn_i, expr)
`define TSFM_ASSERT_IMP(name, clk_i, rstn_i, ante, cons)
`endif

`endif

// File: rtl/tsfm_pkg.sv
package tsfm_pkg;

  localparam int MAX_RESULTS = 64;
  localparam int SAMPLE_W    = 16;
  localparam int THR_W       = 16;
  localparam int IDLE_W      = 17;
  localparam int Q_DEPTH     = 4;
  localparam int Q_AW        = 2;

  localparam logic [THR_W-1:0]  THR_RESET = 16'd500;
  localparam logic [IDLE_W-1:0] IDLE_MAX  = '1;

  typedef enum logic [1:0] {
    CMD_MIC   = 2'd0,
    CMD_SYS   = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_MIX = 2'd0,
    MODE_MIC = 2'd1,
    MODE_SYS = 2'd2
  } mode_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic busy;
    logic pop_mic;
    logic pop_sys;
  } back_stat_t;

endpackage

// File: rtl/tsfm_ram.sv
module tsfm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/tsfm_queue.sv
module tsfm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tsfm_pkg::mode_t   push_job,
  input  logic              pop,
  output tsfm_pkg::mode_t   pop_job,
  output tsfm_pkg::q_stat_t stat
);

  import tsfm_pkg::*;

  localparam logic [Q_AW:0] CNT_FULL = (Q_AW + 1)'(Q_DEPTH);

  mode_t           job_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, wp_nxt;
  logic [Q_AW-1:0] rp_r, rp_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  always_comb begin
    stat.full  = (cnt_r == CNT_FULL);
    stat.empty = (cnt_r == '0);
    do_push    = push && !stat.full;
    do_pop     = pop && !stat.empty;
    wp_nxt     = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt     = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt    = cnt_r + (Q_AW + 1)'(do_push) - (Q_AW + 1)'(do_pop);
  end

  assign pop_job = job_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      job_r[wp_r] <= push_job;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/tsfm_front.sv
`include "two_source_frame_mixer_core_defines.svh"

module tsfm_front #(
  parameter int FRAME_SAMPLES = 16,
  parameter int FIFO_DEPTH    = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             in_cmd,
  input  logic signed [tsfm_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                                   in_chunk_end,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tsfm_pkg::THR_W-1:0]             cfg_data,
  output logic                                   mic_wr_en,
  output logic [((FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1)-1:0] mic_wr_addr,
  output logic                                   sys_wr_en,
  output logic [((FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1)-1:0] sys_wr_addr,
  output logic [tsfm_pkg::SAMPLE_W-1:0]          wr_data,
  output logic                                   q_push,
  output tsfm_pkg::mode_t                        q_job,
  input  tsfm_pkg::q_stat_t                      q_stat,
  input  tsfm_pkg::back_stat_t                   back_stat,
  output logic                                   clr
);

  import tsfm_pkg::*;

  localparam int AW     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
  localparam int CW     = (FILL_W > 7) ? FILL_W : 7;
  localparam int MAXF   = MAX_RESULTS / FRAME_SAMPLES;
  localparam int FCNT_W = $clog2(MAXF + 1);

  localparam logic [CW-1:0]     FS_C     = CW'(FRAME_SAMPLES);
  localparam logic [FILL_W-1:0] FS_F     = FILL_W'(FRAME_SAMPLES);
  localparam logic [FILL_W-1:0] DEPTH_F  = FILL_W'(FIFO_DEPTH);
  localparam logic [AW-1:0]     PTR_LAST = AW'(FIFO_DEPTH - 1);
  localparam logic [FCNT_W-1:0] MAXF_C   = FCNT_W'(MAXF);

  typedef enum logic {F_IDLE, F_EMIT} fstate_t;

  fstate_t           state_r, state_nxt;
  logic [THR_W-1:0]  thr_r, thr_nxt;
  logic [AW-1:0]     mic_wp_r, mic_wp_nxt, sys_wp_r, sys_wp_nxt;
  logic [FILL_W-1:0] mic_fill_r, mic_fill_nxt, sys_fill_r, sys_fill_nxt;
  logic [FILL_W-1:0] mic_occ_r, mic_occ_nxt, sys_occ_r, sys_occ_nxt;
  logic [IDLE_W-1:0] mic_idle_r, mic_idle_nxt, sys_idle_r, sys_idle_nxt;
  logic              mic_seen_r, mic_seen_nxt, sys_seen_r, sys_seen_nxt;
  mode_t             mode_r, mode_nxt;
  logic [FCNT_W-1:0] fcnt_r, fcnt_nxt;

  cmd_t              cmd;
  logic              is_smp, tgt_mic, room, blocked, clr_block, acc, wr, chunk;
  logic [FILL_W-1:0] tgt_fill, tgt_occ;
  logic              ma, sa, need_mic, need_sys, avail, go;

  always_comb begin
    cmd       = cmd_t'(in_cmd);
    is_smp    = (cmd == CMD_MIC) || (cmd == CMD_SYS);
    tgt_mic   = (cmd == CMD_MIC);
    tgt_fill  = tgt_mic ? mic_fill_r : sys_fill_r;
    tgt_occ   = tgt_mic ? mic_occ_r : sys_occ_r;
    room      = (tgt_fill != DEPTH_F);
    // every slot still holds data the back end has not read yet
    blocked   = is_smp && room && (tgt_occ == DEPTH_F);
    clr_block = (cmd == CMD_CLEAR) && (!q_stat.empty || back_stat.busy);
    in_stall  = (state_r != F_IDLE) || blocked || clr_block;
    acc       = in_valid && !in_stall;
    wr        = acc && is_smp && room;
    chunk     = acc && is_smp && in_chunk_end;
    clr       = acc && (cmd == CMD_CLEAR);

    mic_wr_en   = wr && tgt_mic;
    sys_wr_en   = wr && !tgt_mic;
    mic_wr_addr = mic_wp_r;
    sys_wr_addr = sys_wp_r;
    wr_data     = in_sample;
    cfg_ready   = 1'b1;

    ma = tgt_mic  || (mic_seen_r && (mic_idle_r <= {1'b0, thr_r}));
    sa = !tgt_mic || (sys_seen_r && (sys_idle_r <= {1'b0, thr_r}));

    need_mic = (mode_r == MODE_MIX) || (mode_r == MODE_MIC);
    need_sys = (mode_r == MODE_MIX) || (mode_r == MODE_SYS);
    avail    = (!need_mic || (CW'(mic_fill_r) >= FS_C)) &&
               (!need_sys || (CW'(sys_fill_r) >= FS_C));
    go       = avail && (fcnt_r != MAXF_C);
    q_push   = (state_r == F_EMIT) && go && !q_stat.full;
    q_job    = mode_r;

    thr_nxt = cfg_valid ? cfg_data : thr_r;

    state_nxt = state_r;
    mode_nxt  = mode_r;
    fcnt_nxt  = fcnt_r;
    unique case (state_r)
      F_IDLE: begin
        if (chunk && (ma || sa)) begin
          state_nxt = F_EMIT;
          fcnt_nxt  = '0;
          if (ma && sa) begin
            mode_nxt = MODE_MIX;
          end else if (ma) begin
            mode_nxt = MODE_MIC;
          end else begin
            mode_nxt = MODE_SYS;
          end
        end
      end
      F_EMIT: begin
        if (!go) begin
          state_nxt = F_IDLE;
        end else if (q_push) begin
          fcnt_nxt = fcnt_r + 1'b1;
        end
      end
      default: state_nxt = F_IDLE;
    endcase

    mic_wp_nxt   = mic_wp_r;
    sys_wp_nxt   = sys_wp_r;
    mic_fill_nxt = mic_fill_r;
    sys_fill_nxt = sys_fill_r;
    mic_occ_nxt  = mic_occ_r + FILL_W'(mic_wr_en) - FILL_W'(back_stat.pop_mic);
    sys_occ_nxt  = sys_occ_r + FILL_W'(sys_wr_en) - FILL_W'(back_stat.pop_sys);
    mic_idle_nxt = mic_idle_r;
    sys_idle_nxt = sys_idle_r;
    mic_seen_nxt = mic_seen_r;
    sys_seen_nxt = sys_seen_r;

    if (mic_wr_en) begin
      mic_wp_nxt   = (mic_wp_r == PTR_LAST) ? '0 : mic_wp_r + 1'b1;
      mic_fill_nxt = mic_fill_r + 1'b1;
    end
    if (sys_wr_en) begin
      sys_wp_nxt   = (sys_wp_r == PTR_LAST) ? '0 : sys_wp_r + 1'b1;
      sys_fill_nxt = sys_fill_r + 1'b1;
    end
    if (q_push && need_mic) begin
      mic_fill_nxt = mic_fill_r - FS_F;
    end
    if (q_push && need_sys) begin
      sys_fill_nxt = sys_fill_r - FS_F;
    end
    if (chunk && tgt_mic) begin
      mic_seen_nxt = 1'b1;
      mic_idle_nxt = '0;
    end
    if (chunk && !tgt_mic) begin
      sys_seen_nxt = 1'b1;
      sys_idle_nxt = '0;
    end
    if (acc && (cmd == CMD_TICK)) begin
      if (mic_idle_r != IDLE_MAX) mic_idle_nxt = mic_idle_r + 1'b1;
      if (sys_idle_r != IDLE_MAX) sys_idle_nxt = sys_idle_r + 1'b1;
    end
    if (clr) begin
      mic_wp_nxt   = '0;
      sys_wp_nxt   = '0;
      mic_fill_nxt = '0;
      sys_fill_nxt = '0;
      mic_occ_nxt  = '0;
      sys_occ_nxt  = '0;
      mic_idle_nxt = '0;
      sys_idle_nxt = '0;
      mic_seen_nxt = 1'b0;
      sys_seen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      thr_r      <= THR_RESET;
      mic_wp_r   <= '0;
      sys_wp_r   <= '0;
      mic_fill_r <= '0;
      sys_fill_r <= '0;
      mic_occ_r  <= '0;
      sys_occ_r  <= '0;
      mic_idle_r <= '0;
      sys_idle_r <= '0;
      mic_seen_r <= 1'b0;
      sys_seen_r <= 1'b0;
      mode_r     <= MODE_MIX;
      fcnt_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      thr_r      <= thr_nxt;
      mic_wp_r   <= mic_wp_nxt;
      sys_wp_r   <= sys_wp_nxt;
      mic_fill_r <= mic_fill_nxt;
      sys_fill_r <= sys_fill_nxt;
      mic_occ_r  <= mic_occ_nxt;
      sys_occ_r  <= sys_occ_nxt;
      mic_idle_r <= mic_idle_nxt;
      sys_idle_r <= sys_idle_nxt;
      mic_seen_r <= mic_seen_nxt;
      sys_seen_r <= sys_seen_nxt;
      mode_r     <= mode_nxt;
      fcnt_r     <= fcnt_nxt;
    end
  end

  `TSFM_ASSERT(a_mic_occ_covers_fill, clk, rst_n, mic_occ_r >= mic_fill_r)
  `TSFM_ASSERT(a_sys_occ_covers_fill, clk, rst_n, sys_occ_r >= sys_fill_r)
  `TSFM_ASSERT_IMP(a_clear_when_drained, clk, rst_n, clr, !back_stat.busy && q_stat.empty)
  `TSFM_ASSERT_IMP(a_mic_pop_has_data, clk, rst_n, back_stat.pop_mic, mic_occ_r != '0)
  `TSFM_ASSERT_IMP(a_sys_pop_has_data, clk, rst_n, back_stat.pop_sys, sys_occ_r != '0)

endmodule

// File: rtl/tsfm_back.sv
module tsfm_back #(
  parameter int FRAME_SAMPLES = 16,
  parameter int FIFO_DEPTH    = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  tsfm_pkg::q_stat_t                      q_stat,
  input  tsfm_pkg::mode_t                        q_job,
  output logic                                   q_pop,
  input  logic                                   clr,
  output logic                                   mic_rd_en,
  output logic [((FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1)-1:0] mic_rd_addr,
  input  logic [tsfm_pkg::SAMPLE_W-1:0]          mic_rd_data,
  output logic                                   sys_rd_en,
  output logic [((FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1)-1:0] sys_rd_addr,
  input  logic [tsfm_pkg::SAMPLE_W-1:0]          sys_rd_data,
  output tsfm_pkg::back_stat_t                   stat,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [tsfm_pkg::SAMPLE_W-1:0]   out_sample,
  output logic                                   out_frame_last,
  output logic [1:0]                             out_source_mode
);

  import tsfm_pkg::*;

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int IW = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;

  localparam logic [AW-1:0] PTR_LAST = AW'(FIFO_DEPTH - 1);
  localparam logic [IW-1:0] IDX_LAST = IW'(FRAME_SAMPLES - 1);

  typedef enum logic [1:0] {B_IDLE, B_RD, B_DAT} bstate_t;

  bstate_t             state_r, state_nxt;
  mode_t               mode_r, mode_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [AW-1:0]       mic_rp_r, mic_rp_nxt, sys_rp_r, sys_rp_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                frame_last_r, frame_last_nxt;
  logic [1:0]          source_mode_r, source_mode_nxt;

  logic                use_mic, use_sys, out_free, load;
  logic [SAMPLE_W:0]   sum;
  logic [SAMPLE_W-1:0] res;

  always_comb begin
    use_mic  = (mode_r != MODE_SYS);
    use_sys  = (mode_r != MODE_MIC);
    out_free = !out_valid_r || !out_stall;
    load     = (state_r == B_DAT) && out_free;

    q_pop       = (state_r == B_IDLE) && !q_stat.empty;
    mic_rd_en   = (state_r == B_RD) && use_mic;
    sys_rd_en   = (state_r == B_RD) && use_sys;
    mic_rd_addr = mic_rp_r;
    sys_rd_addr = sys_rp_r;

    stat.busy    = (state_r != B_IDLE);
    stat.pop_mic = mic_rd_en;
    stat.pop_sys = sys_rd_en;

    sum = {mic_rd_data[SAMPLE_W-1], mic_rd_data} + {sys_rd_data[SAMPLE_W-1], sys_rd_data};
    case (mode_r)
      MODE_MIX: begin
        if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
          res = sum[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
          res = sum[SAMPLE_W-1:0];
        end
      end
      MODE_MIC: res = mic_rd_data;
      MODE_SYS: res = sys_rd_data;
      default:  res = '0;
    endcase

    state_nxt  = state_r;
    mode_nxt   = mode_r;
    idx_nxt    = idx_r;
    mic_rp_nxt = mic_rp_r;
    sys_rp_nxt = sys_rp_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_pop) begin
          mode_nxt  = q_job;
          idx_nxt   = '0;
          state_nxt = B_RD;
        end
      end
      B_RD: begin
        if (mic_rd_en) mic_rp_nxt = (mic_rp_r == PTR_LAST) ? '0 : mic_rp_r + 1'b1;
        if (sys_rd_en) sys_rp_nxt = (sys_rp_r == PTR_LAST) ? '0 : sys_rp_r + 1'b1;
        state_nxt = B_DAT;
      end
      B_DAT: begin
        if (load) begin
          if (idx_r == IDX_LAST) begin
            state_nxt = B_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = B_RD;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
    if (clr) begin
      mic_rp_nxt = '0;
      sys_rp_nxt = '0;
    end

    out_valid_nxt   = load || (out_valid_r && out_stall);
    out_sample_nxt  = load ? res : out_sample_r;
    frame_last_nxt  = load ? (idx_r == IDX_LAST) : frame_last_r;
    source_mode_nxt = load ? mode_r : source_mode_r;
  end

  always_ff @(posedge clk) begin
    out_sample_r  <= out_sample_nxt;
    frame_last_r  <= frame_last_nxt;
    source_mode_r <= source_mode_nxt;
    if (!rst_n) begin
      state_r     <= B_IDLE;
      mode_r      <= MODE_MIX;
      idx_r       <= '0;
      mic_rp_r    <= '0;
      sys_rp_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      idx_r       <= idx_nxt;
      mic_rp_r    <= mic_rp_nxt;
      sys_rp_r    <= sys_rp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample      = out_sample_r;
  assign out_frame_last  = frame_last_r;
  assign out_source_mode = source_mode_r;

endmodule

// File: rtl/two_source_frame_mixer_core.sv
// channel  | handshake                 | payload
// in_      | in_valid / in_stall       | in_cmd[2], in_sample[16] signed, in_chunk_end
// out_     | out_valid / out_stall     | out_sample[16] signed, out_frame_last, out_source_mode[2]
// cfg_     | cfg_valid / cfg_ready     | cfg_data[16] = inactive threshold in ms
//
// A chunk end that books frames holds in_stall while it pushes them, one job each, into
// the four-entry job queue, longer while the queue is full.
// Back end: RAM read, then output load (held by out_stall) per sample; a job pop per frame.
// Sync active-low reset: FIFOs empty, sources unseen, threshold 500 ms.
// A sample stalls while all of its FIFO slots await readout, but is dropped if all hold
// unframed samples; a clear stalls until the back end and its job queue are drained.
module two_source_frame_mixer_core #(
  parameter int FRAME_SAMPLES = 16,
  parameter int FIFO_DEPTH    = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_cmd,
  input  logic signed [tsfm_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                 in_chunk_end,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [tsfm_pkg::SAMPLE_W-1:0] out_sample,
  output logic                                 out_frame_last,
  output logic [1:0]                           out_source_mode,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tsfm_pkg::THR_W-1:0]           cfg_data
);

  import tsfm_pkg::*;

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  logic                mic_wr_en, sys_wr_en, mic_rd_en, sys_rd_en;
  logic [AW-1:0]       mic_wr_addr, sys_wr_addr, mic_rd_addr, sys_rd_addr;
  logic [SAMPLE_W-1:0] wr_data, mic_rd_data, sys_rd_data;
  logic                q_push, q_pop, clr;
  mode_t               q_push_job, q_pop_job;
  q_stat_t             q_stat;
  back_stat_t          back_stat;

  tsfm_front #(
    .FRAME_SAMPLES (FRAME_SAMPLES),
    .FIFO_DEPTH    (FIFO_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_sample    (in_sample),
    .in_chunk_end (in_chunk_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mic_wr_en    (mic_wr_en),
    .mic_wr_addr  (mic_wr_addr),
    .sys_wr_en    (sys_wr_en),
    .sys_wr_addr  (sys_wr_addr),
    .wr_data      (wr_data),
    .q_push       (q_push),
    .q_job        (q_push_job),
    .q_stat       (q_stat),
    .back_stat    (back_stat),
    .clr          (clr)
  );

  tsfm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (FIFO_DEPTH)
  ) u_mic_ram (
    .clk     (clk),
    .wr_en   (mic_wr_en),
    .wr_addr (mic_wr_addr),
    .wr_data (wr_data),
    .rd_en   (mic_rd_en),
    .rd_addr (mic_rd_addr),
    .rd_data (mic_rd_data)
  );

  tsfm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (FIFO_DEPTH)
  ) u_sys_ram (
    .clk     (clk),
    .wr_en   (sys_wr_en),
    .wr_addr (sys_wr_addr),
    .wr_data (wr_data),
    .rd_en   (sys_rd_en),
    .rd_addr (sys_rd_addr),
    .rd_data (sys_rd_data)
  );

  tsfm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .pop_job  (q_pop_job),
    .stat     (q_stat)
  );

  tsfm_back #(
    .FRAME_SAMPLES (FRAME_SAMPLES),
    .FIFO_DEPTH    (FIFO_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_job           (q_pop_job),
    .q_pop           (q_pop),
    .clr             (clr),
    .mic_rd_en       (mic_rd_en),
    .mic_rd_addr     (mic_rd_addr),
    .mic_rd_data     (mic_rd_data),
    .sys_rd_en       (sys_rd_en),
    .sys_rd_addr     (sys_rd_addr),
    .sys_rd_data     (sys_rd_data),
    .stat            (back_stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample      (out_sample),
    .out_frame_last  (out_frame_last),
    .out_source_mode (out_source_mode)
  );

endmodule

// File: sim/two_source_frame_mixer_core_test.sv
`timescale 1ns / 1ps

module two_source_frame_mixer_core_test;
  import tsfm_pkg::*;

  localparam int FRAME_SAMPLES = 16;
  localparam int FIFO_DEPTH    = 64;
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 2000;

  typedef struct {
    cmd_t               cmd;
    logic signed [15:0] smp;
    logic               ce;
  } mix_in_t;

  typedef struct {
    logic signed [15:0] smp;
    logic               last;
    mode_t              mode;
  } mix_out_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_cmd = CMD_TICK;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                     in_chunk_end = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                     out_frame_last;
  logic [1:0]               out_source_mode;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [THR_W-1:0]         cfg_data = '0;

  two_source_frame_mixer_core #(
    .FRAME_SAMPLES(FRAME_SAMPLES),
    .FIFO_DEPTH   (FIFO_DEPTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_sample      (in_sample),
    .in_chunk_end   (in_chunk_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample     (out_sample),
    .out_frame_last (out_frame_last),
    .out_source_mode(out_source_mode),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // mixer state as seen from outside
  logic signed [15:0] mic_fifo[$];
  logic signed [15:0] sys_fifo[$];
  logic [IDLE_W-1:0]  mic_idle = '0;
  logic [IDLE_W-1:0]  sys_idle = '0;
  bit                 mic_seen = 1'b0;
  bit                 sys_seen = 1'b0;
  logic [THR_W-1:0]   mix_threshold = THR_RESET;

  mix_in_t  stim_items[$];
  mix_out_t mix_expected[$];

  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int frames_mix = 0;
  int frames_mic = 0;
  int frames_sys = 0;
  int n_clipped = 0;
  int n_dropped = 0;

  bit      tx_busy = 1'b0;
  int      tx_gap = 0;
  int      tx_calm = 0;
  int      rx_wait = 0;
  int      rx_calm = 0;
  int      quiet = 0;
  mix_in_t tx_item;

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic void push_sample(cmd_t src, logic signed [15:0] smp);
    if (src == CMD_MIC) begin
      if (mic_fifo.size() < FIFO_DEPTH) mic_fifo.push_back(smp);
      else n_dropped++;
    end else begin
      if (sys_fifo.size() < FIFO_DEPTH) sys_fifo.push_back(smp);
      else n_dropped++;
    end
  endfunction

  function automatic void predict_mix(mix_in_t it);
    bit ma;
    bit sa;
    int frames;
    int v;
    mode_t md;
    mix_out_t r;
    n_in++;
    case (it.cmd)
      CMD_TICK: begin
        if (mic_idle != IDLE_MAX) mic_idle++;
        if (sys_idle != IDLE_MAX) sys_idle++;
      end
      CMD_CLEAR: begin
        mic_fifo.delete();
        sys_fifo.delete();
        mic_idle = '0;
        sys_idle = '0;
        mic_seen = 1'b0;
        sys_seen = 1'b0;
      end
      default: begin
        push_sample(it.cmd, it.smp);
        if (it.ce) begin
          if (it.cmd == CMD_MIC) begin
            mic_seen = 1'b1;
            mic_idle = '0;
          end else begin
            sys_seen = 1'b1;
            sys_idle = '0;
          end
          ma = mic_seen && (mic_idle <= mix_threshold);
          sa = sys_seen && (sys_idle <= mix_threshold);
          frames = 0;
          while (frames < MAX_RESULTS / FRAME_SAMPLES) begin
            if (ma && sa) begin
              if (mic_fifo.size() < FRAME_SAMPLES || sys_fifo.size() < FRAME_SAMPLES) break;
              md = MODE_MIX;
              frames_mix++;
            end else if (ma) begin
              if (mic_fifo.size() < FRAME_SAMPLES) break;
              md = MODE_MIC;
              frames_mic++;
            end else if (sa) begin
              if (sys_fifo.size() < FRAME_SAMPLES) break;
              md = MODE_SYS;
              frames_sys++;
            end else begin
              break;
            end
            for (int i = 0; i < FRAME_SAMPLES; i++) begin
              if (md == MODE_MIX) begin
                v = mic_fifo.pop_front() + sys_fifo.pop_front();
                if (v > 32767) begin
                  v = 32767;
                  n_clipped++;
                end else if (v < -32768) begin
                  v = -32768;
                  n_clipped++;
                end
              end else if (md == MODE_MIC) begin
                v = mic_fifo.pop_front();
              end else begin
                v = sys_fifo.pop_front();
              end
              r.smp  = v[15:0];
              r.last = (i == FRAME_SAMPLES - 1);
              r.mode = md;
              mix_expected.push_back(r);
            end
            frames++;
          end
        end
      end
    endcase
  endfunction

  // sender
  always @(posedge clk) begin : tx_side
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_busy = 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_mix(tx_item);
        tx_busy = 1'b0;
      end
      if (!(in_valid && in_stall)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (stim_items.size() != 0) begin
          tx_item = stim_items.pop_front();
          tx_busy = 1'b1;
          in_valid <= 1'b1;
          in_cmd <= tx_item.cmd;
          in_sample <= tx_item.smp;
          in_chunk_end <= tx_item.ce;
          tx_gap = draw_wait(tx_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin : rx_side
    mix_out_t want;
    int n;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      n = rx_wait;
      if (out_valid && !out_stall) begin
        n = draw_wait(rx_calm);
        n_out++;
        if (mix_expected.size() == 0) begin
          $display("%0t unexpected transfer: sample %0d last %0b mode %0d", $time,
                   out_sample, out_frame_last, out_source_mode);
          errors++;
        end else begin
          want = mix_expected.pop_front();
          if (out_sample !== want.smp) begin
            $display("%0t out_sample: expected %0d, got %0d", $time, want.smp, out_sample);
            errors++;
          end
          if (out_frame_last !== want.last) begin
            $display("%0t out_frame_last: expected %0b, got %0b", $time, want.last,
                     out_frame_last);
            errors++;
          end
          if (out_source_mode !== want.mode) begin
            $display("%0t out_source_mode: expected %0d, got %0d", $time, want.mode,
                     out_source_mode);
            errors++;
          end
        end
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        rx_wait = n - 1;
      end else begin
        out_stall <= 1'b0;
        rx_wait = 0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t timeout: no transfer for %0d cycles, %0d samples outstanding", $time,
                 quiet, mix_expected.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic void queue_item(cmd_t c, logic signed [15:0] s, logic ce);
    mix_in_t it;
    it.cmd = c;
    it.smp = s;
    it.ce  = ce;
    stim_items.push_back(it);
  endfunction

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 3))
      0: return 16'sh7FFF - 16'($urandom_range(0, 2000));
      1: return 16'sh8000 + 16'($urandom_range(0, 2000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void add_chunk(cmd_t src, int len, bit close);
    for (int i = 0; i < len; i++)
      queue_item(src, pick_sample(), close && (i == len - 1));
  endfunction

  function automatic int random_phase(int target);
    int added;
    int k;
    int len;
    cmd_t src;
    added = 0;
    while (added < target) begin
      k = $urandom_range(0, 99);
      src = $urandom_range(0, 1) ? CMD_SYS : CMD_MIC;
      if (k < 60) begin
        len = $urandom_range(1, 20);
        add_chunk(src, len, 1'b1);
      end else if (k < 80) begin
        len = (mix_threshold < 60) ? $urandom_range(1, mix_threshold + 3) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++) queue_item(CMD_TICK, 16'($urandom), 1'($urandom));
      end else if (k < 90) begin
        len = $urandom_range(1, 6);
        add_chunk(src, len, 1'b0);
      end else begin
        len = 1;
        queue_item(cmd_t'($urandom_range(0, 3)), 16'($urandom), 1'($urandom));
      end
      added += len;
    end
    return added;
  endfunction

  task automatic settle();
    while (stim_items.size() != 0 || tx_busy || mix_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] thr);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= thr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mix_threshold = thr;
  endtask

  initial begin : sequencer
    int mid;
    int n_random;
    n_random = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset threshold: chunk end ignored on tick and clear, one mic frame at full scale
    queue_item(CMD_TICK, 16'sh7FFF, 1'b1);
    queue_item(CMD_CLEAR, 16'sh8000, 1'b1);
    for (int i = 0; i < FRAME_SAMPLES; i++)
      queue_item(CMD_MIC, i[0] ? 16'sh8000 : 16'sh7FFF, i == FRAME_SAMPLES - 1);
    queue_item(CMD_SYS, 16'sh0000, 1'b1);
    queue_item(CMD_MIC, 16'shFFFF, 1'b0);
    queue_item(CMD_TICK, 16'sh0000, 1'b0);
    queue_item(CMD_CLEAR, 16'sh0000, 1'b0);
    settle();

    write_threshold(16'd0);
    n_random += random_phase(6);
    settle();
    write_threshold(16'hFFFF);
    n_random += random_phase(6);
    settle();
    mid = $urandom_range(1, 40);
    write_threshold(16'(mid));
    n_random += random_phase(6);
    settle();

    // overfull system FIFO with chunk end on a dropped sample: a burst of four frames
    write_threshold(16'hFFFF);
    queue_item(CMD_CLEAR, 16'sh1234, 1'b0);
    add_chunk(CMD_SYS, FIFO_DEPTH + 7, 1'b1);
    settle();

    // both sources active: mixed frames once the system side refills
    add_chunk(CMD_MIC, 2 * FRAME_SAMPLES, 1'b1);
    add_chunk(CMD_SYS, 2 * FRAME_SAMPLES, 1'b1);
    settle();

    $display("run covered %0d input transfers (%0d random) and %0d output samples",
             n_in, n_random, n_out);
    $display("frames: %0d mixed (%0d clipped), %0d mic, %0d system; %0d dropped; thr %0d",
             frames_mix, n_clipped, frames_mic, frames_sys, n_dropped, mid);
    if (errors == 0 && mix_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
